// ===== hdl/bsr_pkg.sv =====
// ============================================================================
// bsr_pkg
// Shared types and constants of the beeper sample renderer.
// ============================================================================
package bsr_pkg;

    localparam int CLK_W = 24;
    localparam int CPS_W = 16;
    localparam int VOL_W = 4;
    localparam int SMP_W = 16;
    localparam int CNT_W = 7;

    localparam logic OP_PUSH   = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    localparam logic [2:0] CFG_VOLUME = 3'd0;
    localparam logic [2:0] CFG_CPS    = 3'd1;
    localparam logic [2:0] CFG_MODE   = 3'd2;
    localparam logic [2:0] CFG_BUZZER = 3'd3;
    localparam logic [2:0] CFG_FREQ   = 3'd4;

    typedef struct packed {
        logic             op;
        logic [CLK_W-1:0] clk;
        logic             en;
        logic [CNT_W-1:0] cnt;
    } cmd_t;

endpackage

// ===== hdl/beeper_sample_renderer.sv =====
// ============================================================================
// beeper_sample_renderer
// Renders an emulated speaker beep into signed audio samples.
// ============================================================================
// Requests enter on the s_axis channel: a push request stores one speaker
// event (duration, level) in the event queue; a render request produces
// sample_count samples (at most MAX_SAMPLES) on m_axis, tlast marking the
// final one. Registers are written on the cfg port, only while the block
// is idle: a rule for the user that the block itself does not enforce.
// A two-entry request queue decouples acceptance from the render engine and
// registers each request before it reaches the engine.
// Event mode walks the queue one event per cycle and then runs a restoring
// divide per sample. Rate mode accumulates phase steps into each sample.
// Silenced samples and the samples after the queue runs dry skip the divide.
// Pushes are taken in the idle state; a push to a full queue is dropped.
// Reset clears the queue count, head, speaker level and phase; stored
// event entries are not cleared.
// When the receiver stalls, the sample waits in the output register and the
// engine holds at its next sample; the request queue accepts until full.
// ============================================================================
module beeper_sample_renderer
    import bsr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int MAX_SAMPLES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // event_clock[23:0], event_enable, sample_count[6:0]
    input  logic        s_axis_tuser,  // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // sample
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [VOL_W-1:0] volume_reg;
    logic [CPS_W-1:0] cps_reg;
    logic             mode_reg;
    logic             buzzer_reg;
    logic [CPS_W-1:0] freq_reg;
    cmd_t             in_cmd, q_cmd;
    logic             q_valid, q_ready;
    logic signed [SMP_W-1:0] smp;

    assign in_cmd.op  = s_axis_tuser;
    assign in_cmd.clk = s_axis_tdata[23:0];
    assign in_cmd.en  = s_axis_tdata[24];
    assign in_cmd.cnt = s_axis_tdata[31:25];
    assign m_axis_tdata = smp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg <= '0;
            cps_reg    <= '0;
            mode_reg   <= 1'b0;
            buzzer_reg <= 1'b0;
            freq_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VOLUME: volume_reg <= cfg_data[VOL_W-1:0];
                CFG_CPS:    cps_reg    <= cfg_data;
                CFG_MODE:   mode_reg   <= cfg_data[0];
                CFG_BUZZER: buzzer_reg <= cfg_data[0];
                CFG_FREQ:   freq_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    bsr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (in_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    bsr_engine #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_engine
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd_valid         (q_valid),
        .cmd_ready         (q_ready),
        .cmd               (q_cmd),
        .volume            (volume_reg),
        .clocks_per_sample (cps_reg),
        .gen_mode          (mode_reg),
        .buzzer_on         (buzzer_reg),
        .freq_step         (freq_reg),
        .o_valid           (m_axis_tvalid),
        .o_ready           (m_axis_tready),
        .o_sample          (smp),
        .o_last            (m_axis_tlast)
    );

endmodule

// ===== hdl/bsr_front.sv =====
// ============================================================================
// bsr_front
// Accepts requests and holds them in a two-entry queue for the render engine.
// ============================================================================
module bsr_front
    import bsr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    cmd_t       q_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] n_reg, n_next;
    logic       push, pop;

    assign in_ready  = (n_reg != 2'd2);
    assign out_valid = (n_reg != 2'd0);
    assign out_cmd   = q_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wp_next = push ? ~wp_reg : wp_reg;
        rp_next = pop ? ~rp_reg : rp_reg;
        n_next  = n_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            n_reg  <= 2'd0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            n_reg  <= n_next;
        end
    end

endmodule

// ===== hdl/bsr_div.sv =====
// ============================================================================
// bsr_div
// Restoring divider producing one quotient bit per cycle.
// ============================================================================
module bsr_div
    import bsr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [39:0]      dividend,
    input  logic [CPS_W-1:0] divisor,
    output logic             done,
    output logic [39:0]      quotient
);

    logic [39:0]      q_reg, q_next;
    logic [CPS_W:0]   r_reg, r_next;
    logic [5:0]       i_reg, i_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CPS_W+1:0] trial;

    assign done     = done_reg;
    assign quotient = q_reg;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        i_next    = i_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            i_next    = 6'd40;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {r_reg, q_reg[39]} - {2'b00, divisor};
            if (!trial[CPS_W+1])
            begin
                r_next = trial[CPS_W:0];
                q_next = {q_reg[38:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[CPS_W-1:0], q_reg[39]};
                q_next = {q_reg[38:0], 1'b0};
            end
            i_next = i_reg - 6'd1;
            if (i_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        i_reg <= i_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

endmodule

// ===== hdl/bsr_engine.sv =====
// ============================================================================
// bsr_engine
// Executes pushes and renders: event queue walk, divider and rate generator.
// ============================================================================
module bsr_engine
    import bsr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int MAX_SAMPLES = 64
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    output logic                    cmd_ready,
    input  cmd_t                    cmd,
    input  logic [VOL_W-1:0]        volume,
    input  logic [CPS_W-1:0]        clocks_per_sample,
    input  logic                    gen_mode,
    input  logic                    buzzer_on,
    input  logic [CPS_W-1:0]        freq_step,
    output logic                    o_valid,
    input  logic                    o_ready,
    output logic signed [SMP_W-1:0] o_sample,
    output logic                    o_last
);

    localparam int QA_W = $clog2(QUEUE_DEPTH);
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_RD    = 8'b00000010,
        S_WALK  = 8'b00000100,
        S_DIV   = 8'b00001000,
        S_DWAIT = 8'b00010000,
        S_RATE  = 8'b00100000,
        S_EMIT  = 8'b01000000,
        S_FLUSH = 8'b10000000
    } state_t;

    logic [CLK_W-1:0] mem_clk [QUEUE_DEPTH];
    logic             mem_en  [QUEUE_DEPTH];
    logic [CLK_W-1:0] rd_clk_reg;
    logic             rd_en_reg;

    state_t           st_reg, st_next;
    logic [QC_W-1:0]  cnt_reg, cnt_next;
    logic [QA_W-1:0]  head_reg, head_next;
    logic             lvl_reg, lvl_next;
    logic [15:0]      ph_reg, ph_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CPS_W-1:0] rem_reg, rem_next;
    logic [CPS_W-1:0] acc_reg, acc_next;
    logic             mode_reg, mode_next;
    logic             rate_reg, rate_next;
    logic             drop_reg, drop_next;
    logic [1:0]       sub_reg, sub_next;
    logic signed [SMP_W-1:0] s_reg, s_next;
    logic signed [SMP_W-1:0] v_reg, v_next;
    logic             ov_reg, ov_next, ol_reg, ol_next;
    logic             wr_en, wb_en;
    logic [31:0]      wr_sum;
    logic [QA_W-1:0]  wr_addr;
    logic [QA_W-1:0]  head_inc;
    logic [CLK_W-1:0] wb_val;
    logic             div_start, div_done;
    logic [39:0]      div_q;
    logic [19:0]      prod;
    logic [39:0]      dividend;
    logic [CNT_W-1:0] n_cut;
    logic [15:0]      ph_add;
    logic signed [SMP_W-1:0] amp;
    logic             ofree;

    assign o_valid  = ov_reg;
    assign o_sample = s_reg;
    assign o_last   = ol_reg;
    assign ofree    = !ov_reg || o_ready;
    assign wr_sum   = 32'(head_reg) + 32'(cnt_reg);
    assign wr_addr  = (wr_sum >= 32'(QUEUE_DEPTH)) ? QA_W'(wr_sum - 32'(QUEUE_DEPTH))
                                                   : QA_W'(wr_sum);
    assign head_inc = (head_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + QA_W'(1);
    assign n_cut    = (cmd.cnt > CNT_W'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES) : cmd.cnt;
    assign ph_add   = ph_reg + freq_step;
    assign amp      = SMP_W'({volume, 8'd0});
    assign prod     = 20'(acc_reg) * 20'(volume);
    assign dividend = {9'd0, prod, 11'd0};

    bsr_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (clocks_per_sample),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_clk[wr_addr] <= cmd.clk;
            mem_en[wr_addr]  <= cmd.en;
        end
        else if (wb_en)
        begin
            mem_clk[head_reg] <= wb_val;
        end
        rd_clk_reg <= mem_clk[head_next];
        rd_en_reg  <= mem_en[head_next];
    end

    always_comb
    begin
        st_next   = st_reg;
        cnt_next  = cnt_reg;
        head_next = head_reg;
        lvl_next  = lvl_reg;
        ph_next   = ph_reg;
        n_next    = n_reg;
        k_next    = k_reg;
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        mode_next = mode_reg;
        rate_next = rate_reg;
        drop_next = drop_reg;
        sub_next  = sub_reg;
        s_next    = s_reg;
        v_next    = v_reg;
        ov_next   = ov_reg && !o_ready;
        ol_next   = ol_reg;
        wr_en     = 1'b0;
        wb_en     = 1'b0;
        wb_val    = rd_clk_reg - CLK_W'(rem_reg);
        div_start = 1'b0;
        cmd_ready = 1'b0;
        unique case (st_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    if (cmd.op == OP_PUSH)
                    begin
                        if (32'(cnt_reg) < QUEUE_DEPTH)
                        begin
                            wr_en    = 1'b1;
                            cnt_next = cnt_reg + QC_W'(1);
                        end
                    end
                    else if (n_cut != '0)
                    begin
                        n_next    = n_cut;
                        k_next    = '0;
                        mode_next = 1'b0;
                        rate_next = 1'b0;
                        drop_next = 1'b0;
                        v_next    = '0;
                        if (volume == '0)
                            st_next = S_FLUSH;
                        else if (!gen_mode)
                        begin
                            if (cnt_reg == '0 || clocks_per_sample == '0)
                                st_next = S_FLUSH;
                            else
                                st_next = S_RD;
                        end
                        else if (buzzer_on && freq_step != '0)
                        begin
                            rate_next = 1'b1;
                            sub_next  = '0;
                            st_next   = S_RATE;
                        end
                        else
                            st_next = S_FLUSH;
                    end
                end
            end
            S_RD:
            begin
                rem_next = clocks_per_sample;
                acc_next = '0;
                st_next  = S_WALK;
            end
            S_WALK:
            begin
                if (CLK_W'(rem_reg) < rd_clk_reg)
                begin
                    if (lvl_reg)
                        acc_next = acc_reg + rem_reg;
                    wb_en   = 1'b1;
                    st_next = S_DIV;
                end
                else
                begin
                    head_next = head_inc;
                    cnt_next  = cnt_reg - QC_W'(1);
                    if (cnt_reg > QC_W'(1))
                    begin
                        rem_next = rem_reg - CPS_W'(rd_clk_reg);
                        if (lvl_reg)
                            acc_next = acc_reg + CPS_W'(rd_clk_reg);
                        lvl_next = rd_en_reg;
                    end
                    else
                    begin
                        if (lvl_reg)
                            acc_next = acc_reg + rem_reg;
                        mode_next = lvl_reg;
                        drop_next = 1'b1;
                        st_next   = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                div_start = 1'b1;
                st_next   = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (div_done)
                begin
                    v_next  = SMP_W'(div_q);
                    st_next = S_EMIT;
                end
            end
            S_RATE:
            begin
                ph_next  = ph_add;
                v_next   = ph_add[15] ? v_reg + amp : v_reg - amp;
                sub_next = sub_reg + 2'd1;
                if (sub_reg == 2'd3)
                    st_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (ofree)
                begin
                    ov_next = 1'b1;
                    s_next  = v_reg;
                    ol_next = (k_reg + CNT_W'(1) == n_reg);
                    k_next  = k_reg + CNT_W'(1);
                    v_next  = mode_reg ? (v_reg >>> 1) : '0;
                    if (k_reg + CNT_W'(1) == n_reg)
                        st_next = S_IDLE;
                    else if (rate_reg)
                    begin
                        sub_next = '0;
                        st_next  = S_RATE;
                    end
                    else if (drop_reg)
                        st_next = S_FLUSH;
                    else
                        st_next = S_RD;
                end
            end
            S_FLUSH:
            begin
                if (ofree)
                begin
                    ov_next = 1'b1;
                    s_next  = v_reg;
                    v_next  = mode_reg ? (v_reg >>> 1) : '0;
                    ol_next = (k_reg + CNT_W'(1) == n_reg);
                    k_next  = k_reg + CNT_W'(1);
                    if (k_reg + CNT_W'(1) == n_reg)
                        st_next = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        k_reg    <= k_next;
        rem_reg  <= rem_next;
        acc_reg  <= acc_next;
        sub_reg  <= sub_next;
        s_reg    <= s_next;
        v_reg    <= v_next;
        mode_reg <= mode_next;
        rate_reg <= rate_next;
        drop_reg <= drop_next;
        ol_reg   <= ol_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            cnt_reg  <= '0;
            head_reg <= '0;
            lvl_reg  <= 1'b0;
            ph_reg   <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            head_reg <= head_next;
            lvl_reg  <= lvl_next;
            ph_reg   <= ph_next;
            ov_reg   <= ov_next;
        end
    end

endmodule
